>>> rtl/awbs_pkg.sv
package awbs_pkg;

  localparam int MAX_ROWS_DEF  = 512;
  localparam int MAX_COLS_DEF  = 512;
  localparam int FRAC_BITS_DEF = 16;

  localparam int COEF_W = 32;
  localparam int SIZE_W = 10;
  localparam int IDX_W  = 3;

  typedef struct packed {
    logic       op;
    logic [8:0] row;
    logic [8:0] col;
    logic [7:0] pixel;
  } req_t;

  typedef struct packed {
    logic [7:0] value;
    logic       outside;
  } res_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_A00  = 3'd0,
    CFG_A01  = 3'd1,
    CFG_A10  = 3'd2,
    CFG_A11  = 3'd3,
    CFG_OFFX = 3'd4,
    CFG_OFFY = 3'd5,
    CFG_ROWS = 3'd6,
    CFG_COLS = 3'd7
  } cfg_idx_t;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_MULX, S_MULY, S_SUMY, S_CHECK, S_RD0, S_RD1, S_RD2, S_RD3,
    S_WAIT, S_BL1, S_BL2, S_DONE
  } state_t;

  typedef struct packed {
    logic       ld;
    logic       wr;
    logic       mul_x;
    logic       mul_y;
    logic       sum_y;
    logic       chk;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       bl1;
    logic       bl2;
  } cmd_t;

  typedef struct packed {
    logic outside_now;
  } sts_t;

endpackage

>>> rtl/awbs_ctrl.sv
module awbs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           op,
  input  awbs_pkg::sts_t sts,
  output awbs_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);
  import awbs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && op == OP_REQUEST) state_next = S_MULX;
      end
      S_MULX:  state_next = S_MULY;
      S_MULY:  state_next = S_SUMY;
      S_SUMY:  state_next = S_CHECK;
      S_CHECK: state_next = sts.outside_now ? S_DONE : S_RD0;
      S_RD0:   state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_RD3;
      S_RD3:   state_next = S_WAIT;
      S_WAIT:  state_next = S_BL1;
      S_BL1:   state_next = S_BL2;
      S_BL2:   state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy   = 1'b0;
        cmd.ld = start && op == OP_REQUEST;
        cmd.wr = start && op == OP_WRITE;
      end
      S_MULX:  cmd.mul_x = 1'b1;
      S_MULY:  cmd.mul_y = 1'b1;
      S_SUMY:  cmd.sum_y = 1'b1;
      S_CHECK: cmd.chk = 1'b1;
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd0;
      end
      S_RD1: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd1;
      end
      S_RD2: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd2;
      end
      S_RD3: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = 2'd3;
      end
      S_BL1:  cmd.bl1 = 1'b1;
      S_BL2:  cmd.bl2 = 1'b1;
      S_DONE: done = 1'b1;
      default: ;
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("controller not idle after result");
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_REQUEST) |=> busy)
    else $error("request did not start work");
  a_wr_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_WRITE) |=> !busy)
    else $error("pixel write stalled the block");
  a_done_alone: assert property (@(posedge clk) disable iff (rst)
    done |-> !cmd.rd_en && !cmd.ld && !cmd.wr)
    else $error("result cycle overlaps other work");

endmodule

>>> rtl/awbs_dp.sv
module awbs_dp #(
  parameter int MAX_ROWS  = awbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = awbs_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = awbs_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  awbs_pkg::req_t                req,
  input  awbs_pkg::cmd_t                cmd,
  input  logic                          done,
  input  logic                          cfg_we,
  input  logic [awbs_pkg::IDX_W-1:0]    cfg_index,
  input  logic [awbs_pkg::COEF_W-1:0]   cfg_data,
  output awbs_pkg::sts_t                sts,
  output awbs_pkg::res_t                res
);
  import awbs_pkg::*;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int F   = FRAC_BITS;
  localparam int XW  = COEF_W + 11;
  localparam int PW  = COEF_W + 10;
  localparam int SZW = 13;
  localparam int F1W = F + 9;
  localparam int ACW = 2 * F + 10;
  localparam logic [SZW-1:0] MR = SZW'(MAX_ROWS);
  localparam logic [SZW-1:0] MC = SZW'(MAX_COLS);
  localparam logic [F:0]     ONE = {1'b1, {F{1'b0}}};

  logic signed [COEF_W-1:0] a00, a01, a10, a11, offx, offy;
  logic [SIZE_W-1:0] src_rows, src_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      a00      <= COEF_W'(1 << 16);
      a01      <= '0;
      a10      <= '0;
      a11      <= COEF_W'(1 << 16);
      offx     <= '0;
      offy     <= '0;
      src_rows <= SIZE_W'(512);
      src_cols <= SIZE_W'(512);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_A00:  a00 <= cfg_data;
        CFG_A01:  a01 <= cfg_data;
        CFG_A10:  a10 <= cfg_data;
        CFG_A11:  a11 <= cfg_data;
        CFG_OFFX: offx <= cfg_data;
        CFG_OFFY: offy <= cfg_data;
        CFG_ROWS: src_rows <= cfg_data[SIZE_W-1:0];
        CFG_COLS: src_cols <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Source frame, row-major; written only by pixel writes.
  logic [7:0] frame [0:(2**(RW+CW))-1];
  logic [7:0] mem_q;
  logic [RW-1:0] rd_row;
  logic [CW-1:0] rd_col;
  logic          wr_ok;

  assign wr_ok = (SZW'(req.row) < MR) && (SZW'(req.col) < MC);

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      frame[{RW'(req.row), CW'(req.col)}] <= req.pixel;
    end
    if (cmd.rd_en) begin
      mem_q <= frame[{rd_row, rd_col}];
    end
  end

  logic [8:0] d_row, d_col;
  logic signed [PW-1:0] p0, p1;
  logic signed [XW-1:0] x, y;
  logic [RW-1:0] ux;
  logic [CW-1:0] ly;
  logic [F-1:0]  fx, fy;
  logic          outside_r;
  logic          cap_vld;
  logic [1:0]    cap_sel;
  logic [7:0]    px [0:3];
  logic [F1W-1:0] f1, f2;
  logic [ACW-1:0] acc;

  logic [SZW-1:0] rows_eff, cols_eff;
  logic signed [XW-1:0] lim_x, lim_y;

  assign rows_eff = (SZW'(src_rows) > MR) ? MR : SZW'(src_rows);
  assign cols_eff = (SZW'(src_cols) > MC) ? MC : SZW'(src_cols);
  assign lim_x = XW'(rows_eff - SZW'(2)) <<< F;
  assign lim_y = XW'(cols_eff - SZW'(2)) <<< F;

  assign sts.outside_now = (rows_eff < SZW'(2)) || (cols_eff < SZW'(2)) ||
                           x[XW-1] || y[XW-1] || (x > lim_x) || (y > lim_y);

  assign rd_row = ux + RW'(cmd.rd_sel[0]);
  assign rd_col = ly + CW'(cmd.rd_sel[1]);

  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      d_row <= req.row;
      d_col <= req.col;
    end
    if (cmd.mul_x) begin
      p0 <= PW'($signed({1'b0, d_row})) * PW'(a00);
      p1 <= PW'($signed({1'b0, d_col})) * PW'(a10);
    end
    if (cmd.mul_y) begin
      x  <= XW'(p0) + XW'(p1) + XW'(offx);
      p0 <= PW'($signed({1'b0, d_row})) * PW'(a01);
      p1 <= PW'($signed({1'b0, d_col})) * PW'(a11);
    end
    if (cmd.sum_y) begin
      y <= XW'(p0) + XW'(p1) + XW'(offy);
    end
    if (cmd.chk) begin
      outside_r <= sts.outside_now;
      ux        <= x[F +: RW];
      ly        <= y[F +: CW];
      fx        <= x[F-1:0];
      fy        <= y[F-1:0];
    end
    cap_sel <= cmd.rd_sel;
    if (cap_vld) begin
      px[cap_sel] <= mem_q;
    end
    // Blend along the row axis first, then along the column axis.
    if (cmd.bl1) begin
      f1 <= F1W'(ONE - {1'b0, fx}) * F1W'(px[0]) + F1W'(fx) * F1W'(px[1]);
      f2 <= F1W'(ONE - {1'b0, fx}) * F1W'(px[2]) + F1W'(fx) * F1W'(px[3]);
    end
    if (cmd.bl2) begin
      acc <= ACW'(ONE - {1'b0, fy}) * ACW'(f1) + ACW'(fy) * ACW'(f2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_vld <= 1'b0;
    end else begin
      cap_vld <= cmd.rd_en;
    end
  end

  assign res.value   = outside_r ? 8'd0 : acc[2*F +: 8];
  assign res.outside = outside_r;

  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (done && res.outside) |-> res.value == 8'd0)
    else $error("outside result carries a value");
  a_cap_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> cap_vld)
    else $error("read data not captured");
  a_blend_stable: assert property (@(posedge clk) disable iff (rst)
    cmd.bl2 |=> $stable(outside_r))
    else $error("outside flag changed during blend");

endmodule

>>> rtl/affine_warp_bilinear_sampler.sv
// Affine warp sampler. A request with op=0 stores one source pixel; busy
// stays low. A request with op=1 maps (row, col) through the inverse affine
// registers, then blends four source pixels. busy is high from the cycle
// after acceptance; the result appears for exactly one cycle with done high,
// after the multiply, sum, check, read, wait and blend states (straight after
// the check when the point falls outside the source), and a new request may
// be accepted the cycle after that. The four neighbor reads go through the
// single read port of the frame memory, one per cycle. The receiver cannot
// stall: capture res whenever done is high. Write configuration only while
// busy is low and no result is pending; cfg_ready is always high.
module affine_warp_bilinear_sampler #(
  parameter int MAX_ROWS  = awbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = awbs_pkg::MAX_COLS_DEF,
  parameter int FRAC_BITS = awbs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  awbs_pkg::req_t              req,
  output logic                        busy,
  output logic                        done,
  output awbs_pkg::res_t              res,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [awbs_pkg::IDX_W-1:0]  cfg_index,
  input  logic [awbs_pkg::COEF_W-1:0] cfg_data
);
  import awbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Configuration is always accepted; there is no back-pressure.
  assign cfg_ready = 1'b1;

  awbs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (req.op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  awbs_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .done      (done),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .res       (res)
  );

endmodule

>>> bench/testbench.sv
module testbench;
  import awbs_pkg::*;

  localparam int FRAME_W = 512;
  localparam int SETTLE  = 16;  // longer than a request takes to complete

  // Golden warp: mirrors the frame contents and the configuration, predicts
  // each sample and compares the samples coming back.
  class warp_scoreboard;
    byte unsigned frame [FRAME_W*FRAME_W];
    bit           written [FRAME_W*FRAME_W];
    int           coef [6];
    logic [9:0]   rows, cols;
    res_t         pending_q [$];
    int           errors;

    function void clear();
      coef = '{65536, 0, 0, 65536, 0, 0};
      rows = 10'd512;
      cols = 10'd512;
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] data);
      if (idx == CFG_ROWS) rows = data[9:0];
      else if (idx == CFG_COLS) cols = data[9:0];
      else coef[idx] = data;
    endfunction

    // Map a destination pixel into the source; return 0 when it falls outside.
    function bit locate(logic [8:0] r, logic [8:0] c, output int ux, output int ly,
                        output longint fx, output longint fy);
      longint x, y, nr, nc;
      nr = (rows > 10'd512) ? 512 : rows;
      nc = (cols > 10'd512) ? 512 : cols;
      x = longint'(r) * longint'(coef[CFG_A00]) + longint'(c) * longint'(coef[CFG_A10])
          + longint'(coef[CFG_OFFX]);
      y = longint'(r) * longint'(coef[CFG_A01]) + longint'(c) * longint'(coef[CFG_A11])
          + longint'(coef[CFG_OFFY]);
      ux = 0; ly = 0; fx = 0; fy = 0;
      if (nr < 2 || nc < 2 || x < 0 || y < 0 || x > ((nr - 2) << 16) || y > ((nc - 2) << 16))
        return 0;
      ux = int'(x >>> 16);
      ly = int'(y >>> 16);
      fx = x & 64'hFFFF;
      fy = y & 64'hFFFF;
      return 1;
    endfunction

    // First neighbor of a request that was never loaded, or -1.
    function int first_hole(req_t q);
      int ux, ly, k;
      longint fx, fy;
      if (q.op != OP_REQUEST || !locate(q.row, q.col, ux, ly, fx, fy)) return -1;
      for (k = 0; k < 4; k++)
        if (!written[(ux + k[0]) * FRAME_W + ly + k[1]])
          return (ux + k[0]) * FRAME_W + ly + k[1];
      return -1;
    endfunction

    function void note(req_t q);
      int ux, ly;
      longint fx, fy;
      longint unsigned f1, f2, acc, p00, p10, p01, p11;
      res_t r;
      if (q.op == OP_WRITE) begin
        frame[{q.row, q.col}] = q.pixel;
        written[{q.row, q.col}] = 1'b1;
        return;
      end
      r = '0;
      if (!locate(q.row, q.col, ux, ly, fx, fy)) begin
        r.outside = 1'b1;
      end else begin
        p00 = frame[ux * FRAME_W + ly];
        p10 = frame[(ux + 1) * FRAME_W + ly];
        p01 = frame[ux * FRAME_W + ly + 1];
        p11 = frame[(ux + 1) * FRAME_W + ly + 1];
        f1 = (65536 - fx) * p00 + fx * p10;
        f2 = (65536 - fx) * p01 + fx * p11;
        acc = (65536 - fy) * f1 + fy * f2;
        r.value = acc[39:32];
      end
      pending_q.push_back(r);
    endfunction

    function void check(res_t got);
      res_t want;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample: value=%0d outside=%0b",
                                   got.value, got.outside);
        return;
      end
      want = pending_q.pop_front();
      if (got.value !== want.value || got.outside !== want.outside) begin
        errors++;
        if (errors <= 10)
          $display("sample mismatch: expected value=%0d outside=%0b, got value=%0d outside=%0b",
                   want.value, want.outside, got.value, got.outside);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  req_t        req = '0;
  logic        busy, done, cfg_ready;
  res_t        res;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  warp_scoreboard sb;
  int  random_items;
  bit  no_idle;

  affine_warp_bilinear_sampler dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy), .done(done),
    .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Capture every sample; the block cannot be stalled.
  always @(posedge clk) begin
    if (!rst && done) sb.check(res);
  end

  // Mostly short gaps, a few long ones, none in burst phases.
  function int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one request and hold it until the block takes it.
  task automatic issue(req_t q);
    int gap;
    start <= 1'b1;
    req <= q;
    do @(posedge clk); while (busy);
    sb.note(q);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Load any missing neighbors first so no unloaded source pixel is sampled.
  task automatic sample(req_t q);
    req_t w;
    int h;
    h = sb.first_hole(q);
    while (h >= 0) begin
      w.op = OP_WRITE;
      w.row = 9'(h / FRAME_W);
      w.col = 9'(h % FRAME_W);
      w.pixel = 8'($urandom_range(0, 255));
      issue(w);
      h = sb.first_hole(q);
    end
    issue(q);
  endtask

  task automatic make_request(logic [8:0] r, logic [8:0] c);
    req_t q;
    q.op = OP_REQUEST;
    q.row = r;
    q.col = c;
    q.pixel = 8'($urandom_range(0, 255));
    sample(q);
  endtask

  task automatic load_pixel(logic [8:0] r, logic [8:0] c, logic [7:0] p);
    req_t q;
    q.op = OP_WRITE;
    q.row = r;
    q.col = c;
    q.pixel = p;
    issue(q);
  endtask

  // Drain all outstanding samples, then let the pipeline settle.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic write_all(logic [31:0] a00, logic [31:0] a01, logic [31:0] a10,
                           logic [31:0] a11, logic [31:0] offx, logic [31:0] offy,
                           logic [9:0] nrows, logic [9:0] ncols);
    drain();
    write_reg(CFG_A00, a00);
    write_reg(CFG_A01, a01);
    write_reg(CFG_A10, a10);
    write_reg(CFG_A11, a11);
    write_reg(CFG_OFFX, offx);
    write_reg(CFG_OFFY, offy);
    write_reg(CFG_ROWS, {22'd0, nrows});
    write_reg(CFG_COLS, {22'd0, ncols});
  endtask

  // Near-identity matrix with a small source so most samples land inside.
  task automatic random_phase(int count);
    int n, nr, nc, r;
    req_t q;
    nr = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 512) : $urandom_range(2, 20);
    nc = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 512) : $urandom_range(2, 20);
    write_all(32'd65536 + $urandom_range(0, 65535) - 32768,
              $urandom_range(0, 32767) - 16384,
              $urandom_range(0, 32767) - 16384,
              32'd65536 + $urandom_range(0, 65535) - 32768,
              $urandom_range(0, (nr + 2) * 65536) - 65536,
              $urandom_range(0, (nc + 2) * 65536) - 65536,
              ($urandom_range(0, 19) == 0) ? 10'($urandom_range(513, 1023)) : 10'(nr),
              ($urandom_range(0, 19) == 0) ? 10'($urandom_range(513, 1023)) : 10'(nc));
    no_idle = ($urandom_range(0, 3) == 0);
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      q = 27'($urandom);
      if (r < 15) begin
        q.op = OP_WRITE;
        issue(q);
      end else if (r < 25) begin
        q.op = OP_REQUEST;
        sample(q);
      end else begin
        make_request(9'($urandom_range(0, nr + 1)), 9'($urandom_range(0, nc + 1)));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset matrix is identity over the full 512x512 frame.
    load_pixel(9'd0, 9'd0, 8'd255);
    load_pixel(9'd511, 9'd511, 8'd255);
    make_request(9'd0, 9'd0);
    make_request(9'd510, 9'd510);   // last inside point on both axes
    make_request(9'd511, 9'd0);     // one row past the edge
    make_request(9'd0, 9'd511);     // one column past the edge
    make_request(9'd511, 9'd511);

    // Half-pixel scale: exercise the fraction weights with full-scale pixels.
    write_all(32'd32768, 32'd0, 32'd0, 32'd32768, 32'd16384, 32'd49152, 10'd8, 10'd8);
    load_pixel(9'd1, 9'd1, 8'd255);
    load_pixel(9'd2, 9'd2, 8'd0);
    make_request(9'd1, 9'd1);
    make_request(9'd3, 9'd2);
    make_request(9'd12, 9'd12);     // maps past the last inside point on both axes, so outside
    make_request(9'd13, 9'd13);

    // Negative mapping and coefficient extremes.
    write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h8000_0000, 32'h7FFF_FFFF, 10'd2, 10'd2);
    make_request(9'd0, 9'd0);
    make_request(9'd511, 9'd511);
    write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 10'd2, 10'd2);
    make_request(9'd300, 9'd1);     // zero matrix maps every point to the source corner
    // Degenerate sizes: everything outside.
    write_all(32'd65536, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 10'd1, 10'd0);
    make_request(9'd0, 9'd0);
    // Oversized frame saturates to the memory size.
    write_all(32'd65536, 32'd0, 32'd0, 32'd65536, 32'h0000_FFFF, 32'h0000_FFFF,
              10'd1023, 10'd1023);
    make_request(9'd509, 9'd509);
    make_request(9'd510, 9'd510);

    random_items = 0;
    while (random_items < 600) begin
      random_phase(75);
      random_items += 75;
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
